// File: hw/rtl/ffra_pkg.sv
// Shared types, codes and defaults of the first-fit range allocator.
`timescale 1ns / 1ps
package ffra_pkg;

  localparam int MAX_RANGES_DEF  = 32;
  localparam int OFFSET_BITS_DEF = 16;
  // Width of block counts seen in the datapath (values up to 2^34-1 blocks).
  localparam int VW = 34;

  localparam logic [1:0] FN_ALLOC = 2'd0;
  localparam logic [1:0] FN_FIXED = 2'd1;
  localparam logic [1:0] FN_FREE  = 2'd2;
  localparam logic [1:0] FN_FIND  = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOSPACE  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_BADADDR  = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  localparam logic [1:0] CFG_POOL_LOW  = 2'd0;
  localparam logic [1:0] CFG_POOL_HIGH = 2'd1;
  localparam logic [1:0] CFG_SHIFT     = 2'd2;
  localparam logic [1:0] CFG_TOP_DOWN  = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] request_size;
    logic [31:0] address;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] range_address;
    logic [15:0] range_blocks;
    logic [5:0]  entries_used;
  } rsp_t;

endpackage

// File: hw/rtl/ffra_if.sv
// Request, response and configuration channel interfaces.
`timescale 1ns / 1ps
interface ffra_req_if;
  logic          valid;
  logic          ready;
  ffra_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ffra_rsp_if;
  logic          valid;
  logic          ready;
  ffra_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ffra_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/ffra_table.sv
// Range table memory: one write port, one read port with registered data.
`timescale 1ns / 1ps
module ffra_table #(
  parameter int DEPTH = ffra_pkg::MAX_RANGES_DEF,
  parameter int WIDTH = 2 * ffra_pkg::OFFSET_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/first_fit_range_allocator_unit.sv
// Top level of the first-fit range allocator.
// Operation: set-up of the geometry (S_GEOM) and the operands (S_OPER), a scan with one
// table entry read per cycle (skipped on an empty table), resolve, a move of the tail
// entries on insert or remove, and a registered response.
// Throughput: one request at a time; a new request is taken only after the response
// to the last one has been registered, and the sequential scan and the tail move
// through the table memory bound how often requests can be taken.
// Reset: synchronous, clears control state and the live count; the table
// memory itself is not cleared, entries beyond the live count are unused.
`timescale 1ns / 1ps
module first_fit_range_allocator_unit #(
  parameter int MAX_RANGES  = ffra_pkg::MAX_RANGES_DEF,
  parameter int OFFSET_BITS = ffra_pkg::OFFSET_BITS_DEF
) (
  input logic     clk,
  input logic     rst,
  ffra_cfg_if.sink   cfg,
  ffra_req_if.sink   req,
  ffra_rsp_if.source rsp
);

  localparam int AW = $clog2(MAX_RANGES);
  localparam int CW = $clog2(MAX_RANGES + 1);
  localparam int OB = OFFSET_BITS;
  localparam int VW = ffra_pkg::VW;
  localparam logic [VW-1:0] OMAX_V = (VW'(1) << OB) - VW'(1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_GEOM  = 7'b0000010,
    S_OPER  = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_RES   = 7'b0010000,
    S_SHIFT = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [31:0] pool_low, pool_high;
  logic [4:0]  block_shift;
  logic        top_down_mode;
  logic [CW-1:0] live_count;

  // Latched request and derived pool geometry.
  logic [1:0]    op_func;
  logic [31:0]   op_size, op_addr;
  logic [31:0]   mask_r, lo_r, hi_r;
  logic [OB-1:0] cap_r;
  logic [VW-1:0] psize_r, fx_lo_r, fx_hi_r;
  logic          aligned_r, bad_r;

  // Scan state.
  logic [VW-1:0] prev;
  logic [CW-1:0] rd_i;
  logic          data_v;
  logic [AW-1:0] data_i;
  logic          found;
  logic [CW-1:0] pos;
  logic [OB-1:0] hit_s, hit_l;

  // Shift state.
  logic          ins, rd_on, pend;
  logic [AW-1:0] sh_rd, sh_last, pend_a, ins_pos;
  logic [OB-1:0] new_s, new_l;

  // Result.
  logic [2:0]    res_status;
  logic [OB-1:0] res_off, res_blk;
  logic          res_use_addr;
  logic          out_v;
  ffra_pkg::rsp_t out_r;

  // Table port.
  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [2*OB-1:0] mem_wdata, mem_rdata;

  ffra_table #(.DEPTH(MAX_RANGES), .WIDTH(2 * OB)) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign cfg.ready = 1'b1;
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_v;
  assign rsp.data  = out_r;

  // Geometry: aligned bounds from the registers.
  logic [31:0] mask_c, lo_c;
  assign mask_c = ~(32'hFFFF_FFFF << block_shift);
  assign lo_c   = 32'(33'(pool_low) + 33'(mask_c)) & ~mask_c;

  // Request decode against the aligned bounds.
  logic [31:0]   hl_diff, cap_sh, dif;
  logic [OB-1:0] cap_c;
  logic [VW-1:0] psize_c, fx_lo_c, fx_hi_c;
  logic [32:0]   end_sum;
  always_comb begin
    hl_diff = hi_r - lo_r;
    cap_sh  = (hi_r > lo_r) ? (hl_diff >> block_shift) : 32'd0;
    cap_c   = (VW'(cap_sh) > OMAX_V) ? OB'(OMAX_V) : OB'(cap_sh);
    psize_c = (VW'(op_size) + VW'(mask_r)) >> block_shift;
    dif     = op_addr - lo_r;
    fx_lo_c = VW'(dif >> block_shift);
    fx_hi_c = (VW'(dif) + VW'(op_size) + VW'(mask_r)) >> block_shift;
    end_sum = 33'(op_addr) + 33'(op_size);
  end

  // Scan: judge the entry that the table returned.
  logic [VW-1:0] ent_s, ent_e, prev_adv;
  logic          hit_c;
  always_comb begin
    ent_s    = VW'(mem_rdata[2*OB-1:OB]);
    ent_e    = ent_s + VW'(mem_rdata[OB-1:0]);
    prev_adv = top_down_mode ? ent_s : ent_e;
    case (op_func)
      ffra_pkg::FN_ALLOC: begin
        hit_c = top_down_mode ? (prev >= ent_e && psize_r <= prev - ent_e)
                              : (ent_s >= prev && psize_r <= ent_s - prev);
      end
      ffra_pkg::FN_FIXED: begin
        hit_c = top_down_mode ? (fx_hi_r >= ent_e) : (fx_lo_r <= ent_s);
      end
      ffra_pkg::FN_FREE: begin
        hit_c = aligned_r && (fx_lo_r == ent_s);
      end
      default: begin
        hit_c = (fx_lo_r >= ent_s) && (fx_lo_r < ent_e);
      end
    endcase
  end

  // Resolve: placement checks after the scan.
  logic [VW-1:0] cap_v, hit_sv, hit_ev, off_c;
  logic          nospace_c, full_c;
  logic [OB-1:0] new_s_c, new_l_c;
  always_comb begin
    cap_v  = VW'(cap_r);
    hit_sv = VW'(hit_s);
    hit_ev = hit_sv + VW'(hit_l);
    off_c  = top_down_mode ? prev - psize_r : prev;
    full_c = (live_count == CW'(MAX_RANGES));
    if (op_func == ffra_pkg::FN_ALLOC) begin
      nospace_c = !found && (top_down_mode ? (prev < psize_r)
                                           : (prev > cap_v || psize_r > cap_v - prev));
      new_s_c = OB'(off_c);
      new_l_c = OB'(psize_r);
    end else begin
      if (top_down_mode) begin
        nospace_c = fx_hi_r > prev || fx_hi_r > cap_v || (found && fx_lo_r < hit_ev);
      end else begin
        nospace_c = fx_lo_r < prev || fx_hi_r > cap_v || (found && fx_hi_r > hit_sv);
      end
      new_s_c = OB'(fx_lo_r);
      new_l_c = OB'(fx_hi_r - fx_lo_r);
    end
  end

  // Table port steering.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pend_a;
    mem_wdata = mem_rdata;
    mem_raddr = '0;
    if (state == S_SCAN) begin
      mem_raddr = rd_i[AW-1:0];
    end else if (state == S_SHIFT) begin
      mem_raddr = sh_rd;
      if (pend) begin
        mem_we = 1'b1;
      end else if (!rd_on && ins) begin
        mem_we    = 1'b1;
        mem_waddr = ins_pos;
        mem_wdata = {new_s, new_l};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      pool_low      <= 32'd0;
      pool_high     <= 32'd0;
      block_shift   <= 5'd12;
      top_down_mode <= 1'b0;
      live_count    <= '0;
      out_v         <= 1'b0;
      data_v        <= 1'b0;
      rd_on         <= 1'b0;
      pend          <= 1'b0;
    end else begin
      if (out_v && rsp.ready) begin
        out_v <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_func <= req.data.func;
            op_size <= req.data.request_size;
            op_addr <= req.data.address;
            state   <= S_GEOM;
          end
        end
        S_GEOM: begin
          mask_r <= mask_c;
          lo_r   <= lo_c;
          hi_r   <= pool_high & ~mask_c;
          state  <= S_OPER;
        end
        S_OPER: begin
          cap_r     <= cap_c;
          psize_r   <= psize_c;
          fx_lo_r   <= fx_lo_c;
          fx_hi_r   <= fx_hi_c;
          aligned_r <= (dif & mask_r) == 32'd0;
          prev      <= top_down_mode ? VW'(cap_c) : '0;
          rd_i      <= '0;
          data_v    <= 1'b0;
          found     <= 1'b0;
          pos       <= live_count;
          if (op_func inside {ffra_pkg::FN_ALLOC, ffra_pkg::FN_FIXED}) begin
            bad_r <= (op_func == ffra_pkg::FN_FIXED) && (end_sum[32] || op_addr < lo_r);
          end else begin
            bad_r <= op_addr < lo_r || op_addr > hi_r;
          end
          // Skip the scan on an empty table.
          state <= (live_count == '0) ? S_RES : S_SCAN;
        end
        S_SCAN: begin
          // Issue the next read while judging the previous one.
          if (rd_i < live_count) begin
            rd_i   <= rd_i + CW'(1);
            data_v <= 1'b1;
            data_i <= rd_i[AW-1:0];
          end else begin
            data_v <= 1'b0;
          end
          if (data_v) begin
            if (hit_c) begin
              found <= 1'b1;
              pos   <= CW'(data_i);
              hit_s <= mem_rdata[2*OB-1:OB];
              hit_l <= mem_rdata[OB-1:0];
              state <= S_RES;
            end else begin
              prev <= prev_adv;
              if (CW'(data_i) == live_count - CW'(1)) begin
                state <= S_RES;
              end
            end
          end
        end
        S_RES: begin
          res_use_addr <= 1'b0;
          res_off      <= '0;
          res_blk      <= '0;
          state        <= S_OUT;
          if (bad_r) begin
            res_status <= ffra_pkg::ST_BADADDR;
          end else begin
            case (op_func)
              ffra_pkg::FN_ALLOC, ffra_pkg::FN_FIXED: begin
                if (nospace_c) begin
                  res_status <= ffra_pkg::ST_NOSPACE;
                end else if (full_c) begin
                  res_status <= ffra_pkg::ST_FULL;
                end else begin
                  res_status <= ffra_pkg::ST_OK;
                  res_off    <= new_s_c;
                  res_blk    <= new_l_c;
                  new_s      <= new_s_c;
                  new_l      <= new_l_c;
                  ins        <= 1'b1;
                  ins_pos    <= pos[AW-1:0];
                  // Move the tail up by one, from the last entry down.
                  rd_on      <= pos < live_count;
                  sh_rd      <= AW'(live_count - CW'(1));
                  sh_last    <= pos[AW-1:0];
                  state      <= S_SHIFT;
                end
              end
              ffra_pkg::FN_FREE: begin
                if (found) begin
                  res_status   <= ffra_pkg::ST_OK;
                  res_blk      <= hit_l;
                  res_use_addr <= 1'b1;
                  ins          <= 1'b0;
                  // Move the tail down by one, from the entry after the hole.
                  rd_on        <= pos + CW'(1) < live_count;
                  sh_rd        <= AW'(pos + CW'(1));
                  sh_last      <= AW'(live_count - CW'(1));
                  state        <= S_SHIFT;
                end else begin
                  res_status <= ffra_pkg::ST_NOTFOUND;
                end
              end
              default: begin
                if (found) begin
                  res_status <= ffra_pkg::ST_OK;
                  res_off    <= hit_s;
                  res_blk    <= hit_l;
                end else begin
                  res_status <= ffra_pkg::ST_NOTFOUND;
                end
              end
            endcase
          end
        end
        S_SHIFT: begin
          pend <= rd_on;
          if (rd_on) begin
            pend_a <= ins ? sh_rd + AW'(1) : sh_rd - AW'(1);
            if (sh_rd == sh_last) begin
              rd_on <= 1'b0;
            end else begin
              sh_rd <= ins ? sh_rd - AW'(1) : sh_rd + AW'(1);
            end
          end
          if (!rd_on && !pend) begin
            live_count <= ins ? live_count + CW'(1) : live_count - CW'(1);
            state      <= S_OUT;
          end
        end
        S_OUT: begin
          // Hold until the output register is free.
          if (!out_v || rsp.ready) begin
            out_v              <= 1'b1;
            out_r.status       <= res_status;
            out_r.range_address <= (res_status != ffra_pkg::ST_OK) ? 32'd0 :
                                   res_use_addr ? op_addr :
                                   lo_r + (32'(res_off) << block_shift);
            out_r.range_blocks <= (res_status != ffra_pkg::ST_OK) ? 16'd0
                                                                  : 16'(res_blk);
            out_r.entries_used <= 6'(live_count);
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // Any register write empties the table.
      if (cfg.valid) begin
        case (cfg.index)
          ffra_pkg::CFG_POOL_LOW:  pool_low      <= cfg.data;
          ffra_pkg::CFG_POOL_HIGH: pool_high     <= cfg.data;
          ffra_pkg::CFG_SHIFT:     block_shift   <= cfg.data[4:0];
          default:                 top_down_mode <= cfg.data[0];
        endcase
        live_count <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live_count <= CW'(MAX_RANGES))
    else $error("live count beyond table depth");

  a_shift_in_table: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && rd_on) |-> (CW'(sh_rd) < live_count))
    else $error("shift reads beyond live entries");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && res_status == ffra_pkg::ST_FULL) |-> full_c)
    else $error("table full reported on a table with room");

  a_out_after_res: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && data_v && hit_c) |=> (state == S_RES && found))
    else $error("scan hit lost");
`endif

endmodule
